>>> rtl/mfd_pkg.sv
package mfd_pkg;

    localparam int RX_BUFFER_BYTES = 64;
    localparam int TX_BUFFER_BYTES = 64;

    localparam int RX_AW = $clog2(RX_BUFFER_BYTES);
    localparam int RX_CW = $clog2(RX_BUFFER_BYTES + 1);
    localparam int TX_AW = $clog2(TX_BUFFER_BYTES);
    localparam int TX_CW = $clog2(TX_BUFFER_BYTES + 1);
    localparam int CNT_W = (RX_CW > TX_CW) ? RX_CW : TX_CW;

    localparam int LEN_W  = 7;
    localparam int KIND_W = 2;

    localparam logic [1:0] OP_RX  = 2'd0;
    localparam logic [1:0] OP_TX  = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ETX  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STX  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CRLF = 2'd2;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_EMIT,
        DEC_CMP
    } t_dec;

    typedef struct packed {
        logic take;
        logic cmp_run;
        logic clear_sent;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        t_dec dec;
        logic cmp_done;
        logic mismatch;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/meter_frame_delimiter_core.sv
// A frame end goes into the result registers at the accepting edge, then via S_EMIT
// into the output register once that is free; a stalled output holds it in S_EMIT.
// A CR LF line as long as the last transmitted frame first walks both byte stores
// (up to 64 bytes); a mismatch gives a result, a match clears the sent count instead.
// Throughput: one item per cycle with no result or walk due, else the input stalls.
// Reset (synchronous, active low) empties both stores and clears the flags.
module meter_frame_delimiter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_new_frame,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mfd_pkg::KIND_W-1:0]  o_end_kind,
    output logic [mfd_pkg::LEN_W-1:0]   o_frame_length,
    output logic [7:0]                  o_check_byte
);
    import mfd_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    mfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mfd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .i_new_frame    (i_new_frame),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_end_kind     (o_end_kind),
        .o_frame_length (o_frame_length),
        .o_check_byte   (o_check_byte)
    );

endmodule

>>> rtl/mfd_ctrl.sv
module mfd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mfd_pkg::t_dp_status i_status,
    output mfd_pkg::t_ctl_cmd   o_cmd
);
    import mfd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_status.dec)
                        DEC_EMIT: n_state = S_EMIT;
                        DEC_CMP:  n_state = S_CMP;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CMP: begin
                if (i_status.cmp_done) begin
                    n_state = i_status.mismatch ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                // hold the result until the output register can take it
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall          = 1'b1;
        o_cmd.take       = 1'b0;
        o_cmd.cmp_run    = 1'b0;
        o_cmd.clear_sent = 1'b0;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.take = i_valid;
            end
            S_CMP: begin
                o_cmd.cmp_run    = 1'b1;
                o_cmd.clear_sent = i_status.cmp_done & ~i_status.mismatch;
            end
            S_EMIT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

>>> rtl/mfd_datapath.sv
module mfd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_new_frame,
    input  mfd_pkg::t_ctl_cmd           i_cmd,
    output mfd_pkg::t_dp_status         o_status,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [mfd_pkg::KIND_W-1:0]  o_end_kind,
    output logic [mfd_pkg::LEN_W-1:0]   o_frame_length,
    output logic [7:0]                  o_check_byte
);
    import mfd_pkg::*;

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [7:0] rx_mem [RX_BUFFER_BYTES];
    logic [7:0] tx_mem [TX_BUFFER_BYTES];

    logic             r_readout_mode;
    logic [RX_CW-1:0] r_rx_count;
    logic [RX_AW-1:0] r_head;
    logic [RX_AW-1:0] r_wr;
    logic             r_start_seen;
    logic             r_text_seen;
    logic [TX_CW-1:0] r_sent_count;
    logic [7:0]       r_last;

    logic [CNT_W-1:0] r_cmp_idx;
    logic [RX_CW-1:0] r_cmp_len;
    logic [RX_AW-1:0] r_rx_addr;
    logic             r_rd_valid;
    logic             r_mismatch;
    logic [7:0]       r_rx_rd;
    logic [7:0]       r_tx_rd;

    logic [KIND_W-1:0] r_res_kind;
    logic [LEN_W-1:0]  r_res_len;
    logic [7:0]        r_res_chk;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [LEN_W-1:0]  r_out_len;
    logic [7:0]        r_out_chk;

    logic             rx_full;
    logic [RX_CW-1:0] n_len;
    logic [RX_AW-1:0] wr_next;
    logic [RX_AW-1:0] head_next;
    logic             is_rx;
    logic             soh_hit;
    logic             etx_hit;
    logic             stx_emit;
    logic             crlf_hit;
    logic             echo_cand;
    t_dec             dec;
    logic [KIND_W-1:0] dec_kind;
    logic [7:0]        dec_chk;
    logic [TX_CW-1:0]  tx_idx;
    logic              tx_write;
    logic              out_free;

    assign rx_full   = (r_rx_count == RX_CW'(RX_BUFFER_BYTES));
    assign n_len     = rx_full ? r_rx_count : r_rx_count + 1'b1;
    assign wr_next   = rx_inc(r_wr);
    assign head_next = rx_full ? rx_inc(r_head) : r_head;
    assign is_rx     = (i_operation == OP_RX);

    // test order: SOH, byte after ETX, STX, CR LF
    assign soh_hit  = (i_data_byte == BYTE_SOH);
    assign etx_hit  = !soh_hit && (r_rx_count != '0) && (r_last == BYTE_ETX);
    assign stx_emit = !soh_hit && !etx_hit && (i_data_byte == BYTE_STX) &&
                      !r_start_seen && (r_rx_count != '0);
    assign crlf_hit = !soh_hit && !etx_hit && (i_data_byte == BYTE_LF) &&
                      (!r_text_seen || r_readout_mode) &&
                      (r_rx_count != '0) && (r_last == BYTE_CR);
    assign echo_cand = (CNT_W'(n_len) == CNT_W'(r_sent_count));

    always_comb begin
        dec      = DEC_NONE;
        dec_kind = KIND_CRLF;
        dec_chk  = 8'h00;
        if (is_rx) begin
            if (etx_hit) begin
                dec      = DEC_EMIT;
                dec_kind = KIND_ETX;
                dec_chk  = i_data_byte;
            end else if (stx_emit) begin
                dec      = DEC_EMIT;
                dec_kind = KIND_STX;
            end else if (crlf_hit) begin
                dec = echo_cand ? DEC_CMP : DEC_EMIT;
            end
        end
    end

    assign tx_idx   = i_new_frame ? '0 : r_sent_count;
    assign tx_write = i_cmd.take && (i_operation == OP_TX) &&
                      (tx_idx < TX_CW'(TX_BUFFER_BYTES));
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_readout_mode <= 1'b0;
            r_rx_count     <= '0;
            r_head         <= '0;
            r_wr           <= '0;
            r_start_seen   <= 1'b0;
            r_text_seen    <= 1'b0;
            r_sent_count   <= '0;
            r_cmp_idx      <= '0;
            r_cmp_len      <= '0;
            r_rx_addr      <= '0;
            r_rd_valid     <= 1'b0;
            r_mismatch     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_readout_mode <= i_cfg_data;
            end

            if (i_cmd.take) begin
                case (i_operation)
                    OP_RX: begin
                        r_wr <= wr_next;
                        if (soh_hit || dec != DEC_NONE) begin
                            r_rx_count <= '0;
                            r_head     <= wr_next;
                        end else begin
                            r_head <= head_next;
                            if (!rx_full) begin
                                r_rx_count <= r_rx_count + 1'b1;
                            end
                        end
                        if (soh_hit) begin
                            r_start_seen <= 1'b1;
                            r_text_seen  <= 1'b0;
                        end else if (etx_hit) begin
                            r_start_seen <= 1'b0;
                            r_text_seen  <= 1'b0;
                        end else if (i_data_byte == BYTE_STX) begin
                            if (r_start_seen) begin
                                r_start_seen <= 1'b0;
                                r_text_seen  <= 1'b1;
                            end else if (r_rx_count == '0) begin
                                r_text_seen <= 1'b1;
                            end
                        end
                        // echo walk starts at the oldest byte of the line
                        r_cmp_idx  <= '0;
                        r_cmp_len  <= n_len;
                        r_rx_addr  <= head_next;
                        r_rd_valid <= 1'b0;
                        r_mismatch <= 1'b0;
                    end
                    OP_TX: begin
                        if (tx_write) begin
                            r_sent_count <= tx_idx + 1'b1;
                        end
                    end
                    OP_CLR: begin
                        r_rx_count <= '0;
                        r_head     <= r_wr;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.cmp_run) begin
                if (r_cmp_idx != CNT_W'(r_cmp_len)) begin
                    r_cmp_idx  <= r_cmp_idx + 1'b1;
                    r_rx_addr  <= rx_inc(r_rx_addr);
                    r_rd_valid <= 1'b1;
                end else begin
                    r_rd_valid <= 1'b0;
                end
                if (r_rd_valid && (r_rx_rd != r_tx_rd)) begin
                    r_mismatch <= 1'b1;
                end
            end

            if (i_cmd.clear_sent) begin
                r_sent_count <= '0;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_rx) begin
            rx_mem[r_wr] <= i_data_byte;
            r_last       <= i_data_byte;
        end
        if (tx_write) begin
            tx_mem[tx_idx[TX_AW-1:0]] <= i_data_byte;
        end
        r_rx_rd <= rx_mem[r_rx_addr];
        r_tx_rd <= tx_mem[r_cmp_idx[TX_AW-1:0]];

        if (i_cmd.take && is_rx) begin
            r_res_kind <= dec_kind;
            r_res_len  <= LEN_W'(n_len);
            r_res_chk  <= dec_chk;
        end
        if (i_cmd.out_load) begin
            r_out_kind <= r_res_kind;
            r_out_len  <= r_res_len;
            r_out_chk  <= r_res_chk;
        end
    end

    assign o_status.dec      = dec;
    assign o_status.cmp_done = (r_cmp_idx == CNT_W'(r_cmp_len)) && !r_rd_valid;
    assign o_status.mismatch = r_mismatch;
    assign o_status.out_free = out_free;

    assign o_valid        = r_out_valid;
    assign o_end_kind     = r_out_kind;
    assign o_frame_length = r_out_len;
    assign o_check_byte   = r_out_chk;

endmodule
